// File: rtl/tpq_pkg.sv
package tpq_pkg;

    // Default number of timer slots held by the block.
    localparam int TIMER_SLOTS_DEF = 16;

    // Input command codes.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // Result kind codes.
    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_WAIT  = 2'd2;

    // Largest wait that is reported, and the code for no armed slot.
    localparam logic signed [31:0] WAIT_CLAMP = 32'sd2147483647;
    localparam logic signed [31:0] WAIT_NONE  = -32'sd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the item's fields
        logic do_start;    // arm the addressed slot
        logic do_stop;     // disarm the addressed slot
        logic scan_clear;  // restart the minimum search
        logic scan_step;   // examine one slot
        logic fire;        // disarm the best slot and report it
        logic emit_done;   // report a done result
        logic emit_wait;   // report the wait value
    } tpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // the slot under examination is the last one
        logic found;       // the search has seen an armed slot
        logic due;         // the best slot's deadline is not after now
    } tpq_status_t;

endpackage

// File: rtl/timer_priority_queue.sv
// Timer slot queue with earliest-deadline search.
//
// Items enter on start, command, slot, delay and now. An item is taken at a
// rising edge where start is high and busy is low; busy then stays high until
// the last result of that item has been issued. Each result appears on kind,
// fired_slot, wait_res and last for exactly one cycle while res_valid is high.
// The receiver has no way to hold results off, so it must take them as issued.
//
// Start and stop answer with one done result, set up in the execute state
// and issued from the result registers. Run and query walk the slots one
// per cycle to find the earliest armed deadline, ties going to the lower
// start order, then to the lower slot, through the single shared comparator
// of the search loop. A query answers with the wait once its search is done.
// A run that fires k slots searches k + 1 times and issues its done result
// after the last search. Busy drops in the cycle the final result is shown,
// so the next item can be taken then.
//
// Reset disarms every slot and clears the start order counter; deadlines and
// orders of disarmed slots are never examined, so they need no clearing.
module timer_priority_queue #(
    parameter int TIMER_SLOTS = tpq_pkg::TIMER_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [3:0]         slot,
    input  logic [62:0]        delay,
    input  logic [63:0]        now,
    output logic               res_valid,
    output logic [1:0]         kind,
    output logic [3:0]         fired_slot,
    output logic signed [31:0] wait_res,
    output logic               last
);
    import tpq_pkg::*;

    tpq_cmd_t    cmd;
    tpq_status_t status;

    // The controller sequences the command; the datapath holds the slots,
    // the search registers and the result registers.
    tpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    tpq_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .slot       (slot),
        .delay      (delay),
        .now        (now),
        .res_valid  (res_valid),
        .kind       (kind),
        .fired_slot (fired_slot),
        .wait_res   (wait_res),
        .last       (last)
    );

`ifndef SYNTHESIS
    // A result only follows a cycle in which an item was being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(busy))
        else $error("result issued without an item in progress");

    // Only a fired slot report can be followed by further results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |-> (kind == KIND_FIRED))
        else $error("non-final result is not a fired slot");

    // After a fired slot the search restarts, so results never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind == KIND_FIRED) |=> !res_valid)
        else $error("result directly after a fired slot report");

    // Taking an item always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
`endif

endmodule

// File: rtl/tpq_ctrl.sv
module tpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           command,
    input  tpq_pkg::tpq_status_t status,
    output tpq_pkg::tpq_cmd_t    cmd,
    output logic                 busy
);
    import tpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg;
    logic       busy_reg;
    logic       accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    if (command == CMD_START || command == CMD_STOP)
                        state_next = S_EXEC;
                    else
                        state_next = S_SCAN;
                end
            end
            S_EXEC:
            begin
                cmd.do_start  = (op_reg == CMD_START);
                cmd.do_stop   = (op_reg == CMD_STOP);
                cmd.emit_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (op_reg == CMD_RUN)
                begin
                    if (status.found && status.due)
                    begin
                        cmd.fire       = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.emit_wait = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_START;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            if (accept)
                op_reg <= command;
        end
    end

endmodule

// File: rtl/tpq_datapath.sv
module tpq_datapath #(
    parameter int TIMER_SLOTS = tpq_pkg::TIMER_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpq_pkg::tpq_cmd_t    cmd,
    output tpq_pkg::tpq_status_t status,
    input  logic [3:0]           slot,
    input  logic [62:0]          delay,
    input  logic [63:0]          now,
    output logic                 res_valid,
    output logic [1:0]           kind,
    output logic [3:0]           fired_slot,
    output logic signed [31:0]   wait_res,
    output logic                 last
);
    import tpq_pkg::*;

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

    // Slot storage; only armed entries are ever examined.
    logic [63:0]            deadline_reg [TIMER_SLOTS];
    logic [63:0]            order_reg    [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] armed_reg;
    logic [63:0]            counter_reg;

    // Captured item fields.
    logic [3:0]  slot_reg;
    logic [62:0] delay_reg;
    logic [63:0] now_reg;

    // Minimum search state.
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [63:0]       best_dl_reg;
    logic [63:0]       best_ord_reg;
    logic              found_reg;

    // Result registers.
    logic              res_valid_reg;
    logic [1:0]        kind_reg;
    logic [3:0]        fired_slot_reg;
    logic signed [31:0] wait_reg;
    logic              last_reg;

    logic              in_range;
    logic [SLOT_W-1:0] slot_idx;
    logic [64:0]       sum_wide;
    logic [63:0]       sum_sat;
    logic [63:0]       cur_dl;
    logic [63:0]       cur_ord;
    logic              better;
    logic [63:0]       diff;
    logic signed [31:0] wait_val;

    assign in_range = ({28'd0, slot_reg} < 32'(TIMER_SLOTS));
    assign slot_idx = SLOT_W'(slot_reg);
    assign sum_wide = {1'b0, now_reg} + {2'b00, delay_reg};
    assign sum_sat  = sum_wide[64] ? '1 : sum_wide[63:0];

    assign cur_dl  = deadline_reg[idx_reg];
    assign cur_ord = order_reg[idx_reg];
    assign better  = armed_reg[idx_reg] &&
                     (!found_reg || (cur_dl < best_dl_reg) ||
                      ((cur_dl == best_dl_reg) && (cur_ord < best_ord_reg)));

    assign diff = best_dl_reg - now_reg;

    always_comb
    begin
        if (!found_reg)
            wait_val = WAIT_NONE;
        else if (best_dl_reg <= now_reg)
            wait_val = '0;
        else if (diff[63:31] != '0)
            wait_val = WAIT_CLAMP;
        else
            wait_val = signed'(diff[31:0]);
    end

    assign status.scan_last = (idx_reg == LAST_IDX);
    assign status.found     = found_reg;
    assign status.due       = (best_dl_reg <= now_reg);

    // Payload and storage registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg  <= slot;
            delay_reg <= delay;
            now_reg   <= now;
        end
        if (cmd.do_start && in_range)
        begin
            deadline_reg[slot_idx] <= sum_sat;
            order_reg[slot_idx]    <= counter_reg;
        end
        if (cmd.scan_step && better)
        begin
            best_idx_reg <= idx_reg;
            best_dl_reg  <= cur_dl;
            best_ord_reg <= cur_ord;
        end
        if (cmd.emit_done)
        begin
            kind_reg       <= KIND_DONE;
            fired_slot_reg <= '0;
            wait_reg       <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.fire)
        begin
            kind_reg       <= KIND_FIRED;
            fired_slot_reg <= 4'(best_idx_reg);
            wait_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_wait)
        begin
            kind_reg       <= KIND_WAIT;
            fired_slot_reg <= '0;
            wait_reg       <= wait_val;
            last_reg       <= 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= '0;
            counter_reg   <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit_done || cmd.fire || cmd.emit_wait;
            if (cmd.do_start && in_range)
            begin
                armed_reg[slot_idx] <= 1'b1;
                counter_reg         <= counter_reg + 64'd1;
            end
            if (cmd.do_stop && in_range)
                armed_reg[slot_idx] <= 1'b0;
            if (cmd.fire)
                armed_reg[best_idx_reg] <= 1'b0;
            if (cmd.scan_clear)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (better)
                    found_reg <= 1'b1;
                if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
    end

    assign res_valid  = res_valid_reg;
    assign kind       = kind_reg;
    assign fired_slot = fired_slot_reg;
    assign wait_res   = wait_reg;
    assign last       = last_reg;

endmodule

// File: tb/tpq_checker.sv
module tpq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         command,
    input  logic [3:0]         slot,
    input  logic [62:0]        delay,
    input  logic [63:0]        now,
    input  logic               res_valid,
    input  logic [1:0]         kind,
    input  logic [3:0]         fired_slot,
    input  logic signed [31:0] wait_res,
    input  logic               last,
    output int                 errors,
    output int                 pending,
    output int                 checked,
    output int                 fired
);
    import tpq_pkg::*;

    localparam int SLOTS = TIMER_SLOTS_DEF;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         fired_slot;
        logic signed [31:0] wait_res;
        logic               last;
    } timer_result_t;

    logic [63:0]   slot_deadline [SLOTS];
    logic [63:0]   slot_order    [SLOTS];
    logic          slot_armed    [SLOTS];
    logic [63:0]   next_order;
    timer_result_t timer_results_q [$];
    int            mismatch_count = 0;
    int            result_count = 0;
    int            fire_count = 0;

    // Earliest armed deadline; ties go to the older start, then the lower slot.
    function automatic int earliest_armed();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_armed[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                (slot_deadline[i] == slot_deadline[best] &&
                 slot_order[i] < slot_order[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic void push_result(logic [1:0] k, logic [3:0] s,
                                        logic signed [31:0] w, logic l);
        timer_result_t r;
        r.kind       = k;
        r.fired_slot = s;
        r.wait_res   = w;
        r.last       = l;
        timer_results_q.push_back(r);
    endfunction

    function automatic void predict_timer_item(logic [1:0] cmd, logic [3:0] idx,
                                               logic [62:0] dly, logic [63:0] t);
        logic [64:0] sum;
        logic [63:0] diff;
        int          best;
        int          count;
        case (cmd)
            CMD_START:
            begin
                if (idx < SLOTS)
                begin
                    sum = {1'b0, t} + {2'b00, dly};
                    slot_deadline[idx] = sum[64] ? '1 : sum[63:0];
                    slot_order[idx]    = next_order;
                    next_order         = next_order + 64'd1;
                    slot_armed[idx]    = 1'b1;
                end
                push_result(KIND_DONE, 4'd0, 32'sd0, 1'b1);
            end
            CMD_STOP:
            begin
                if (idx < SLOTS)
                    slot_armed[idx] = 1'b0;
                push_result(KIND_DONE, 4'd0, 32'sd0, 1'b1);
            end
            CMD_RUN:
            begin
                count = 0;
                best  = earliest_armed();
                while (count < SLOTS && best >= 0 && slot_deadline[best] <= t)
                begin
                    slot_armed[best] = 1'b0;
                    push_result(KIND_FIRED, best[3:0], 32'sd0, 1'b0);
                    count++;
                    best = earliest_armed();
                end
                push_result(KIND_DONE, 4'd0, 32'sd0, 1'b1);
            end
            default:
            begin
                best = earliest_armed();
                if (best < 0)
                    push_result(KIND_WAIT, 4'd0, WAIT_NONE, 1'b1);
                else if (slot_deadline[best] <= t)
                    push_result(KIND_WAIT, 4'd0, 32'sd0, 1'b1);
                else
                begin
                    diff = slot_deadline[best] - t;
                    push_result(KIND_WAIT, 4'd0,
                                diff > 64'(WAIT_CLAMP) ? WAIT_CLAMP : diff[31:0], 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void check_timer_result();
        timer_result_t exp;
        if (timer_results_q.size() == 0)
        begin
            $display("%0t: unexpected result kind=%0d slot=%0d wait=%0d last=%0d",
                     $time, kind, fired_slot, wait_res, last);
            mismatch_count++;
            return;
        end
        exp = timer_results_q.pop_front();
        result_count++;
        if (exp.kind == KIND_FIRED)
            fire_count++;
        if (kind !== exp.kind)
        begin
            $display("%0t: kind expected %0d, got %0d", $time, exp.kind, kind);
            mismatch_count++;
        end
        if (fired_slot !== exp.fired_slot)
        begin
            $display("%0t: fired_slot expected %0d, got %0d", $time, exp.fired_slot,
                     fired_slot);
            mismatch_count++;
        end
        if (wait_res !== exp.wait_res)
        begin
            $display("%0t: wait_res expected %0d, got %0d", $time, exp.wait_res, wait_res);
            mismatch_count++;
        end
        if (last !== exp.last)
        begin
            $display("%0t: last expected %0d, got %0d", $time, exp.last, last);
            mismatch_count++;
        end
    endfunction

    // Results are checked before the new item is predicted; the new item's
    // results can only come out on later cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_deadline[i] = '0;
                slot_order[i]    = '0;
                slot_armed[i]    = 1'b0;
            end
            next_order = '0;
            timer_results_q.delete();
        end
        else
        begin
            if (res_valid === 1'b1)
                check_timer_result();
            if (start === 1'b1 && busy === 1'b0)
                predict_timer_item(command, slot, delay, now);
        end
        errors  <= mismatch_count;
        pending <= timer_results_q.size();
        checked <= result_count;
        fired   <= fire_count;
    end

endmodule

// File: tb/timer_priority_queue_test.sv
// The top makes the stimulus and gives the verdict. All prediction and
// comparison happens in the checker instance beside the block.
module timer_priority_queue_test;
    import tpq_pkg::*;

    localparam logic [62:0] DELAY_MAX = '1;
    localparam logic [63:0] TIME_MAX  = '1;
    localparam int          ITEM_GOAL = 270;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         command = CMD_START;
    logic [3:0]         slot = '0;
    logic [62:0]        delay = '0;
    logic [63:0]        now = '0;
    logic               busy;
    logic               res_valid;
    logic [1:0]         kind;
    logic [3:0]         fired_slot;
    logic signed [31:0] wait_res;
    logic               last;

    int                 errors;
    int                 pending;
    int                 checked;
    int                 fired;

    // Stimulus bookkeeping: items sent per command, the longest idle gap
    // currently allowed, and a loop time that mostly moves forward.
    int                 cmd_count [4] = '{0, 0, 0, 0};
    int                 items_sent = 0;
    int                 gap_max = 10;
    logic [63:0]        loop_time = '0;

    always #5 clk = ~clk;

    timer_priority_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .slot       (slot),
        .delay      (delay),
        .now        (now),
        .res_valid  (res_valid),
        .kind       (kind),
        .fired_slot (fired_slot),
        .wait_res   (wait_res),
        .last       (last)
    );

    tpq_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .slot       (slot),
        .delay      (delay),
        .now        (now),
        .res_valid  (res_valid),
        .kind       (kind),
        .fired_slot (fired_slot),
        .wait_res   (wait_res),
        .last       (last),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .fired      (fired)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one item. A random idle gap comes first; with no gap, start simply
    // stays high from the previous item, so it is never lowered and raised in
    // the same step. The item is taken at the first edge where busy is low.
    // Busy is read right after the edge, so it still holds its pre-edge value.
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [62:0] dly, input logic [63:0] t);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        slot    <= idx;
        delay   <= dly;
        now     <= t;
        do @(posedge clk); while (busy !== 1'b0);
        cmd_count[cmd]++;
        items_sent++;
    endtask

    // A well-formed burst: arm a run of distinct slots with short delays while
    // the loop time creeps forward, stop or query now and then, then let time
    // pass and ask for the wait and fire what has expired.
    task automatic arm_and_fire(input int count, input int spread);
        int base;
        base = $urandom_range(0, 15);
        for (int i = 0; i < count; i++)
        begin
            loop_time = loop_time + 64'($urandom_range(0, 20));
            send_item(CMD_START, 4'(base + i), 63'($urandom_range(0, spread)), loop_time);
            case ($urandom_range(0, 7))
                0: send_item(CMD_STOP, 4'($urandom_range(0, 15)), 63'(rand64()), loop_time);
                1: send_item(CMD_QUERY, 4'($urandom), 63'(rand64()), loop_time);
                default: ;
            endcase
        end
        loop_time = loop_time + 64'($urandom_range(0, 2 * spread));
        send_item(CMD_QUERY, 4'($urandom), 63'(rand64()), loop_time);
        send_item(CMD_RUN, 4'($urandom), 63'(rand64()), loop_time);
    endtask

    // Noise: any command with fields drawn across their whole range, including
    // huge delays that saturate or clamp, and jumps of the loop time.
    task automatic random_command();
        logic [62:0] dly;
        logic [63:0] t;
        case ($urandom_range(0, 4))
            0: dly = 63'(rand64());
            1: dly = 63'h7fff_ff00 + 63'($urandom_range(0, 512));
            2: dly = DELAY_MAX - 63'($urandom_range(0, 3));
            default: dly = 63'($urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 5))
            0: t = rand64();
            1: t = TIME_MAX - 64'($urandom_range(0, 1000));
            2:
            begin
                loop_time = rand64();
                t = loop_time;
            end
            default: t = loop_time;
        endcase
        send_item(2'($urandom_range(0, 3)), 4'($urandom), dly, t);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Nothing armed yet: the query reports no slot and the
        // run only answers done; stopping an idle slot changes nothing.
        send_item(CMD_QUERY, 4'd0, '0, '0);
        send_item(CMD_RUN, 4'd0, '0, '0);
        send_item(CMD_STOP, 4'd7, '0, '0);
        // A zero delay is due at once.
        send_item(CMD_START, 4'd0, '0, '0);
        send_item(CMD_QUERY, 4'd0, '0, '0);
        // Deadline overflow saturates to all ones; a sum that lands exactly on
        // all ones must not count as overflow.
        send_item(CMD_START, 4'd15, DELAY_MAX, TIME_MAX);
        send_item(CMD_START, 4'd1, DELAY_MAX, 64'h8000_0000_0000_0000);
        send_item(CMD_START, 4'd2, 63'd1, TIME_MAX);
        send_item(CMD_START, 4'd3, 63'd100, 64'd1000);
        send_item(CMD_RUN, 4'd0, '0, 64'd1000);
        send_item(CMD_QUERY, 4'd0, '0, 64'd1000);
        // A far deadline clamps the reported wait once the near one is stopped.
        send_item(CMD_START, 4'd4, 63'h100_0000_0000, 64'd1000);
        send_item(CMD_STOP, 4'd3, '0, 64'd1000);
        send_item(CMD_QUERY, 4'd0, '0, 64'd1000);
        send_item(CMD_START, 4'd5, 63'd2147483647, 64'd0);
        // Equal deadlines fall back to start order; restarting slot 6 makes it
        // younger than slot 7 even though its index is lower.
        send_item(CMD_START, 4'd6, 63'd50, 64'd1050);
        send_item(CMD_START, 4'd7, 63'd100, 64'd1000);
        send_item(CMD_START, 4'd6, 63'd100, 64'd1000);
        send_item(CMD_STOP, 4'd4, '0, 64'd1000);
        send_item(CMD_QUERY, 4'd0, '0, 64'd1099);
        send_item(CMD_RUN, 4'd0, '0, 64'd1100);
        send_item(CMD_RUN, 4'd0, '0, TIME_MAX);
        send_item(CMD_QUERY, 4'd0, '0, TIME_MAX);

        // Every slot armed and due at once gives the longest run.
        loop_time = 64'd5000;
        arm_and_fire(16, 0);

        // Random part: mostly bursts, some noise, and now and then a stretch
        // with no idle gaps at all.
        while (items_sent < ITEM_GOAL)
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            if ($urandom_range(0, 9) < 6)
                arm_and_fire($urandom_range(1, 16),
                             ($urandom_range(0, 3) == 0) ? 5000 : 200);
            else
                repeat ($urandom_range(1, 4)) random_command();
        end
        start <= 1'b0;

        // Drain: pending lags one edge behind the checker, so the first look is
        // taken after an edge. Then give the block time to show any stray result.
        do @(posedge clk); while (pending != 0);
        repeat (2 * (TIMER_SLOTS_DEF + 2)) @(posedge clk);

        $display("Sent %0d items: %0d starts, %0d stops, %0d runs, %0d queries.",
                 items_sent, cmd_count[CMD_START], cmd_count[CMD_STOP],
                 cmd_count[CMD_RUN], cmd_count[CMD_QUERY]);
        $display("Checked %0d results, %0d of them expired-slot reports.", checked, fired);
        if (errors == 0)
            $display("PASS timer_priority_queue");
        else
            $display("FAIL timer_priority_queue");
        $finish;
    end

    // Safety net in case the block stops answering.
    initial
    begin
        #5_000_000;
        $display("FAIL timer_priority_queue");
        $finish;
    end

endmodule
